// File: src/atlas_request_selector_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the request selector
// Implication checks on the clock, held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ATLAS_REQUEST_SELECTOR_CORE_ASSERT_SVH
`define ATLAS_REQUEST_SELECTOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define ARS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define ARS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ARS_ASSERT_SAME(label, clk, rst, ante, cons)

`define ARS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/ars_pkg.sv
// ----------------------------------------------------------------------------
// ars_pkg
// Widths and shared types of the request selector.
// ----------------------------------------------------------------------------
package ars_pkg;

  localparam int unsigned BUFFER_DEPTH = 32;
  localparam int unsigned NUM_THREADS  = 16;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned ID_W         = $clog2(BUFFER_DEPTH);
  localparam int unsigned RANK_W       = $clog2(NUM_THREADS);

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [RANK_W-1:0] rank_t;

  typedef struct packed {
    id_t   entry_id;
    time_t arrive_time;
    rank_t thread_rank;
    logic  row_ready;
    time_t current_time;
    logic  last_entry;
  } item_t;

endpackage

// File: src/ars_req_if.sv
// ----------------------------------------------------------------------------
// ars_req_if
// Request entry channel: one buffer entry per transaction.
// ----------------------------------------------------------------------------
interface ars_req_if;
  import ars_pkg::*;

  logic  valid;
  logic  ready;
  id_t   entry_id;
  time_t arrive_time;
  rank_t thread_rank;
  logic  row_ready;
  time_t current_time;
  logic  last_entry;

  modport source (
    output valid, entry_id, arrive_time, thread_rank, row_ready, current_time,
           last_entry,
    input  ready
  );

  modport sink (
    input  valid, entry_id, arrive_time, thread_rank, row_ready, current_time,
           last_entry,
    output ready
  );
endinterface

// File: src/ars_rsp_if.sv
// ----------------------------------------------------------------------------
// ars_rsp_if
// Result channel: the chosen slot of one scan per transaction.
// ----------------------------------------------------------------------------
interface ars_rsp_if;
  import ars_pkg::*;

  logic valid;
  logic ready;
  id_t  best_id;

  modport source (output valid, best_id, input ready);
  modport sink   (input valid, best_id, output ready);
endinterface

// File: src/ars_cfg_if.sv
// ----------------------------------------------------------------------------
// ars_cfg_if
// Configuration write channel for the age threshold register.
// ----------------------------------------------------------------------------
interface ars_cfg_if;
  import ars_pkg::*;

  logic  valid;
  logic  ready;
  time_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: src/atlas_request_selector_core.sv
// ----------------------------------------------------------------------------
// atlas_request_selector_core
// Running-best request picker for a memory controller scan.
// ----------------------------------------------------------------------------
// One buffer entry is taken per cycle unless a last entry is stalled. An entry
// is registered, then its age and the held best's age are checked against the
// threshold, and the priority compare updates the running best when the
// selector takes it; taking the entry marked last loads best_id. The result
// register decouples the output side: entries keep flowing while a result
// waits, and only a further last entry stalls behind an untaken result.
// The threshold register takes a write in any cycle; write it while idle.
module atlas_request_selector_core (
  input  logic     clk,
  input  logic     rst,
  ars_cfg_if.sink  cfg,
  ars_req_if.sink  req,
  ars_rsp_if.source rsp
);
  import ars_pkg::*;

  `include "atlas_request_selector_core_assert.svh"

  time_t age_threshold;
  logic  s1_valid;
  item_t s1_item;
  logic  advance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      age_threshold <= '0;
    end else if (cfg.valid && cfg.ready) begin
      age_threshold <= cfg.data;
    end
  end

  ars_input_stage u_input (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  ars_select u_select (
    .clk           (clk),
    .rst           (rst),
    .age_threshold (age_threshold),
    .s1_valid      (s1_valid),
    .s1_item       (s1_item),
    .advance       (advance),
    .rsp           (rsp)
  );

  `ARS_ASSERT_NEXT(a_last_gives_result, clk, rst, advance && s1_item.last_entry, rsp.valid)
  `ARS_ASSERT_NEXT(a_no_spurious_result, clk, rst, !rsp.valid && !(advance && s1_item.last_entry), !rsp.valid)
  `ARS_ASSERT_NEXT(a_stalled_entry_held, clk, rst, s1_valid && !advance, s1_valid && $stable(s1_item))
  `ARS_ASSERT_SAME(a_stall_only_on_last, clk, rst, s1_valid && !advance, s1_item.last_entry && rsp.valid && !rsp.ready)
endmodule

// File: src/ars_input_stage.sv
// ----------------------------------------------------------------------------
// ars_input_stage
// Input register: captures one entry and holds it until the selector takes it.
// ----------------------------------------------------------------------------
module ars_input_stage (
  input  logic           clk,
  input  logic           rst,
  ars_req_if.sink        req,
  input  logic           advance,
  output logic           s1_valid,
  output ars_pkg::item_t s1_item
);
  import ars_pkg::*;

  logic req_fire;
  logic s1_valid_next;

  assign req.ready = !s1_valid || advance;
  assign req_fire  = req.valid && req.ready;

  always_comb begin
    priority if (req_fire) begin
      s1_valid_next = 1'b1;
    end else if (advance) begin
      s1_valid_next = 1'b0;
    end else begin
      s1_valid_next = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_item.entry_id     <= req.entry_id;
      s1_item.arrive_time  <= req.arrive_time;
      s1_item.thread_rank  <= req.thread_rank;
      s1_item.row_ready    <= req.row_ready;
      s1_item.current_time <= req.current_time;
      s1_item.last_entry   <= req.last_entry;
    end
  end
endmodule

// File: src/ars_select.sv
// ----------------------------------------------------------------------------
// ars_select
// Compares the registered entry with the running best and holds the result.
// ----------------------------------------------------------------------------
module ars_select (
  input  logic           clk,
  input  logic           rst,
  input  ars_pkg::time_t age_threshold,
  input  logic           s1_valid,
  input  ars_pkg::item_t s1_item,
  output logic           advance,
  ars_rsp_if.source      rsp
);
  import ars_pkg::*;

  logic  have_best;
  id_t   best_slot;
  time_t best_arrival;
  rank_t best_rank;
  logic  best_ready;
  logic  out_valid;
  id_t   out_id;

  time_t new_age;
  time_t held_age;
  logic  new_over;
  logic  held_over;
  logic  new_wins;
  logic  take;
  logic  out_free;

  // held best's age is taken against this entry's time stamp
  assign new_age   = s1_item.current_time - s1_item.arrive_time;
  assign held_age  = s1_item.current_time - best_arrival;
  assign new_over  = new_age > age_threshold;
  assign held_over = held_age > age_threshold;

  always_comb begin
    priority if (new_over != held_over) begin
      new_wins = new_over;
    end else if (s1_item.thread_rank != best_rank) begin
      new_wins = s1_item.thread_rank < best_rank;
    end else if (s1_item.row_ready != best_ready) begin
      new_wins = s1_item.row_ready;
    end else begin
      new_wins = s1_item.arrive_time < best_arrival;
    end
  end

  assign take     = !have_best || new_wins;
  assign out_free = !out_valid || rsp.ready;
  assign advance  = s1_valid && (!s1_item.last_entry || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        have_best <= !s1_item.last_entry;
      end
      if (advance && s1_item.last_entry) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && take) begin
      best_slot    <= s1_item.entry_id;
      best_arrival <= s1_item.arrive_time;
      best_rank    <= s1_item.thread_rank;
      best_ready   <= s1_item.row_ready;
    end
    if (advance && s1_item.last_entry) begin
      out_id <= take ? s1_item.entry_id : best_slot;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.best_id = out_id;
endmodule

// File: dv/ars_selector_checker.sv
// ----------------------------------------------------------------------------
// ars_selector_checker
// Watches the threshold write, entry and result channels of the request
// selector. Tracks the running best candidate of each scan, queues the
// expected winner when the last entry is taken, and compares every result
// transaction against the oldest queued winner.
// ----------------------------------------------------------------------------
module ars_selector_checker (
  input  logic clk,
  input  logic rst,
  ars_cfg_if   cfg,
  ars_req_if   req,
  ars_rsp_if   rsp,
  output int   mismatches,
  output int   waiting
);
  import ars_pkg::*;

  time_t threshold;
  logic  held;
  id_t   held_slot;
  time_t held_arrival;
  rank_t held_rank;
  logic  held_over;
  logic  held_ready;
  id_t   winner_q[$];

  initial begin
    mismatches = 0;
    waiting    = 0;
  end

  function automatic logic aged_out(time_t now, time_t arrival);
    time_t age;
    age = now - arrival;
    return age > threshold;
  endfunction

  function automatic logic entry_beats_held(logic over, rank_t rank, logic rdy,
                                            time_t arrival);
    if (over != held_over) return over;
    if (rank != held_rank) return rank < held_rank;
    if (rdy != held_ready) return rdy;
    if (arrival != held_arrival) return arrival < held_arrival;
    return 1'b0;
  endfunction

  task automatic clear_best();
    held         = 1'b0;
    held_slot    = '0;
    held_arrival = '0;
    held_rank    = '0;
    held_over    = 1'b0;
    held_ready   = 1'b0;
  endtask

  task automatic track_entry(input item_t it);
    logic over;
    logic take;
    over = aged_out(it.current_time, it.arrive_time);
    if (held) begin
      // held best is aged again against this entry's clock
      held_over = aged_out(it.current_time, held_arrival);
      take = entry_beats_held(over, it.thread_rank, it.row_ready, it.arrive_time);
    end else begin
      take = 1'b1;
    end
    if (take) begin
      held_slot    = it.entry_id;
      held_arrival = it.arrive_time;
      held_rank    = it.thread_rank;
      held_over    = over;
      held_ready   = it.row_ready;
    end
    held = 1'b1;
    if (it.last_entry) begin
      winner_q.push_back(held_slot);
      clear_best();
    end
  endtask

  task automatic report(input string what, input id_t want, input id_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected best_id %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin : monitor
    item_t it;
    id_t   want;
    if (rst) begin
      threshold = '0;
      clear_best();
      winner_q.delete();
    end else begin
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
        threshold = cfg.data;
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (winner_q.size() == 0) begin
          report("result with no scan pending", 'x, rsp.best_id);
        end else begin
          want = winner_q.pop_front();
          if (rsp.best_id !== want)
            report("best_id mismatch", want, rsp.best_id);
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        it.entry_id     = req.entry_id;
        it.arrive_time  = req.arrive_time;
        it.thread_rank  = req.thread_rank;
        it.row_ready    = req.row_ready;
        it.current_time = req.current_time;
        it.last_entry   = req.last_entry;
        track_entry(it);
      end
    end
    waiting <= winner_q.size();
  end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for atlas_request_selector_core. A directed set of
// scans covers each priority rule, full ties, clock wrap, the threshold
// boundary and a held best aged by a moving clock; then random scans run
// under several age thresholds, with random gaps on both channels and one
// long result stall that backs the block up into its entry channel.
// ----------------------------------------------------------------------------
module testbench;
  import ars_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASE_ITEMS = 125;

  logic  clk;
  logic  rst;
  int    mismatches;
  int    waiting;
  int    cycles;
  bit    calm;
  bit    hold_rsp;
  time_t thr_now;
  time_t clock_now;

  ars_cfg_if cfg_if ();
  ars_req_if req_if ();
  ars_rsp_if rsp_if ();

  atlas_request_selector_core dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .req (req_if),
    .rsp (rsp_if)
  );

  ars_selector_checker winner_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_if),
    .req        (req_if),
    .rsp        (rsp_if),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t mk(int id, time_t arr, int rank, bit rdy, time_t now, bit last);
    item_t it;
    it.entry_id     = id_t'(id);
    it.arrive_time  = arr;
    it.thread_rank  = rank_t'(rank);
    it.row_ready    = rdy;
    it.current_time = now;
    it.last_entry   = last;
    return it;
  endfunction

  function automatic item_t random_entry(time_t now, bit last, item_t prev);
    item_t it;
    time_t age;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // copy of the previous entry: exercises ties down to arrival time
      it = prev;
      it.entry_id = id_t'($urandom);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40)      age = thr_now + time_t'($urandom_range(0, 4)) - time_t'(2);
      else if (r < 70) age = time_t'($urandom_range(0, 64));
      else if (r < 85) age = time_t'($urandom);
      else             age = thr_now - time_t'($urandom_range(0, 1000));
      it.entry_id    = id_t'($urandom);
      it.arrive_time = now - age;
      it.thread_rank = ($urandom_range(0, 1) == 0) ? rank_t'($urandom_range(0, 2))
                                                   : rank_t'($urandom_range(0, 15));
      it.row_ready   = 1'($urandom_range(0, 1));
    end
    it.current_time = now;
    it.last_entry   = last;
    return it;
  endfunction

  task automatic send_entry(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.entry_id     <= it.entry_id;
    req_if.arrive_time  <= it.arrive_time;
    req_if.thread_rank  <= it.thread_rank;
    req_if.row_ready    <= it.row_ready;
    req_if.current_time <= it.current_time;
    req_if.last_entry   <= it.last_entry;
    do @(posedge clk); while (req_if.ready !== 1'b1);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_threshold(input time_t value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    thr_now = value;
  endtask

  task automatic run_scans(input int quota);
    int    sent;
    int    len;
    int    r;
    item_t prev;
    item_t it;
    time_t now;
    sent = 0;
    prev = mk(0, 0, 0, 0, 0, 0);
    while (sent < quota) begin
      r = $urandom_range(0, 99);
      if (r < 10)      len = 1;
      else if (r < 80) len = $urandom_range(2, 6);
      else if (r < 95) len = $urandom_range(7, 16);
      else             len = $urandom_range(17, 32);
      if ($urandom_range(0, 9) == 0) clock_now = time_t'($urandom);
      else                           clock_now += time_t'($urandom_range(1, 50));
      now = clock_now;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 7) == 0) now += time_t'($urandom_range(1, 20));
        it = random_entry(now, k == len - 1, prev);
        send_entry(it);
        prev = it;
        sent++;
      end
    end
  endtask

  initial begin
    int n;
    forever begin
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_rsp = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    time_t thr_set[6];
    thr_set = '{32'd0, 32'hFFFF_FFFF, 32'd16, 32'h8000_0000, 32'd1000, 32'd0};
    calm     = 1'b0;
    hold_rsp = 1'b0;
    thr_now  = '0;
    clock_now = time_t'($urandom);
    rst                 <= 1'b1;
    req_if.valid        <= 1'b0;
    req_if.entry_id     <= '0;
    req_if.arrive_time  <= '0;
    req_if.thread_rank  <= '0;
    req_if.row_ready    <= 1'b0;
    req_if.current_time <= '0;
    req_if.last_entry   <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.data         <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_threshold(32'd100);
    // single-entry scans at the field extremes
    send_entry(mk(31, 32'hFFFF_FFFF, 15, 1, 32'd0, 1));
    send_entry(mk(0, 32'd0, 0, 0, 32'd0, 1));
    // over threshold beats lower rank
    send_entry(mk(1, 32'd1000, 0, 1, 32'd1050, 0));
    send_entry(mk(2, 32'd800, 15, 0, 32'd1050, 1));
    // lower rank beats row ready
    send_entry(mk(3, 32'd1000, 5, 1, 32'd1050, 0));
    send_entry(mk(4, 32'd1000, 3, 0, 32'd1050, 1));
    // row ready beats older arrival
    send_entry(mk(5, 32'd990, 7, 0, 32'd1050, 0));
    send_entry(mk(6, 32'd1000, 7, 1, 32'd1050, 1));
    // older arrival wins
    send_entry(mk(7, 32'd1020, 7, 1, 32'd1050, 0));
    send_entry(mk(8, 32'd1010, 7, 1, 32'd1050, 1));
    // full tie keeps the held entry
    send_entry(mk(9, 32'd1030, 2, 1, 32'd1050, 0));
    send_entry(mk(10, 32'd1030, 2, 1, 32'd1050, 1));
    // held best goes over threshold as the clock moves
    send_entry(mk(11, 32'd0, 5, 0, 32'd50, 0));
    send_entry(mk(12, 32'd150, 0, 1, 32'd200, 1));
    // age across clock wrap
    send_entry(mk(13, 32'hFFFF_FFF0, 9, 0, 32'd10, 0));
    send_entry(mk(14, 32'hFFFF_FF00, 9, 0, 32'd10, 1));
    // age equal to threshold is not over
    send_entry(mk(15, 32'd900, 4, 0, 32'd1000, 0));
    send_entry(mk(16, 32'd899, 8, 0, 32'd1000, 0));
    send_entry(mk(17, 32'd880, 8, 0, 32'd1000, 1));
    drain();

    thr_set[5] = time_t'($urandom);
    for (int p = 0; p < 6; p++) begin
      write_threshold(thr_set[p]);
      calm = (p == 2 || p == 4);
      if (p == 2) hold_rsp = 1'b1;
      run_scans(PHASE_ITEMS);
      calm = 1'b0;
      drain();
    end

    if (mismatches == 0 && waiting == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/ars_pkg.sv
src/ars_req_if.sv
src/ars_rsp_if.sv
src/ars_cfg_if.sv
src/ars_input_stage.sv
src/ars_select.sv
src/atlas_request_selector_core.sv
dv/ars_selector_checker.sv
dv/testbench.sv
